[rtl/lfmc_pkg.sv]
// Shared types, constants and helper functions for the line follower mode controller.
// Depends on nothing; every other file in the block but the checker refers to it by scoped names.

package lfmc_pkg;

    // Field and register widths.
    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_W    = 12;
    localparam int THR_W       = 12;
    localparam int IV_W        = 32;
    localparam int CNT_W       = 8;
    localparam int WORD_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // Converter readings keep only the bits the sensor actually delivers.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // Bar graph layout.
    localparam int BAR_STEP        = 410;
    localparam int BAR_COUNT       = 9;
    localparam int MIDDLE_BASE     = 10;
    localparam int RIGHT_BASE      = 20;
    localparam int LEFT_LINE_BIT   = 9;
    localparam int MIDDLE_LINE_BIT = 19;
    localparam int RIGHT_LINE_BIT  = 29;
    localparam int MARK_BIT        = 31;

    // Register reset values.
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd2048;
    localparam logic [IV_W-1:0]  INTERVAL_RESET  = 32'd1000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 1'b1;

    // Command characters.
    localparam logic [7:0] CH_START   = 8'h53;  // S
    localparam logic [7:0] CH_REMOTE  = 8'h44;  // D
    localparam logic [7:0] CH_PAUSE   = 8'h50;  // P
    localparam logic [7:0] CH_TROUBLE = 8'h54;  // T
    localparam logic [7:0] CH_TEST    = 8'h74;  // t
    localparam logic [7:0] CH_FWD     = 8'h77;  // w
    localparam logic [7:0] CH_LEFT    = 8'h61;  // a
    localparam logic [7:0] CH_BACK    = 8'h73;  // s
    localparam logic [7:0] CH_RIGHT   = 8'h64;  // d
    localparam logic [7:0] CH_ROT_L   = 8'h71;  // q
    localparam logic [7:0] CH_ROT_R   = 8'h65;  // e
    localparam logic [7:0] CH_EXIT    = 8'h30;  // 0
    localparam logic [7:0] CH_REPORT  = 8'h70;  // p

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_REMOTE,
        MODE_PAUSE,
        MODE_TROUBLE
    } mode_t;

    typedef enum logic [2:0] {
        MOTOR_NONE,
        MOTOR_STOP,
        MOTOR_FWD,
        MOTOR_BACK,
        MOTOR_TURN_L,
        MOTOR_TURN_R,
        MOTOR_ROT_L,
        MOTOR_ROT_R
    } motor_t;

    typedef enum logic [4:0] {
        MSG_NONE,
        MSG_START,
        MSG_REMOTE,
        MSG_PAUSE,
        MSG_TROUBLE,
        MSG_SAD,
        MSG_W,
        MSG_A,
        MSG_S,
        MSG_D,
        MSG_Q,
        MSG_E,
        MSG_EXIT,
        MSG_X,
        MSG_BAR,
        MSG_SLASH,
        MSG_BACKSLASH,
        MSG_LT,
        MSG_GT
    } msg_t;

    // Line detection flags of the three sensors.
    typedef struct packed {
        logic left;
        logic middle;
        logic right;
    } line_t;

    // Blink comparison targets, derived at reset and whenever the interval is written.
    typedef struct packed {
        logic [31:0] i1;          // I
        logic [32:0] i2;          // 2I
        logic [33:0] i3;          // 3I
        logic [33:0] i4;          // 4I
        logic [30:0] half;        // I/2
        logic [32:0] three_half;  // 3I/2
    } blink_tgt_t;

    // One input word.
    typedef struct packed {
        logic                action;
        logic [7:0]          command_char;
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] middle_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } item_t;

    // One result word.
    typedef struct packed {
        motor_t              motor_cmd;
        logic                bar_valid;
        logic [WORD_W-1:0]   bar_word;
        msg_t                message;
        logic                telemetry_valid;
        logic [SAMPLE_W-1:0] report_left;
        logic [SAMPLE_W-1:0] report_middle;
        logic [SAMPLE_W-1:0] report_right;
    } res_t;

    // Build all blink targets from a new interval value.
    function automatic blink_tgt_t blink_targets(input logic [IV_W-1:0] iv);
        logic [33:0] x3;
        blink_tgt_t  t;
        x3           = 34'(iv) + 34'({iv, 1'b0});
        t.i1         = iv;
        t.i2         = {iv, 1'b0};
        t.i3         = x3;
        t.i4         = {iv, 2'b00};
        t.half       = iv[31:1];
        t.three_half = x3[33:1];
        return t;
    endfunction

endpackage

[rtl/lfmc_bar_encode.sv]
// Sensor bar graph encoder: thermometer bars and line bits for three samples.
// Depends on lfmc_pkg.

module lfmc_bar_encode (
    input  logic [lfmc_pkg::SAMPLE_W-1:0] left_sample,
    input  logic [lfmc_pkg::SAMPLE_W-1:0] middle_sample,
    input  logic [lfmc_pkg::SAMPLE_W-1:0] right_sample,
    input  logic [lfmc_pkg::THR_W-1:0]    line_threshold,
    output logic [lfmc_pkg::WORD_W-1:0]   bar_word,
    output lfmc_pkg::line_t               line
);

    // One bar per full step of the converter range, saturating at the bar count.
    function automatic logic [lfmc_pkg::BAR_COUNT-1:0] thermo(
        input logic [lfmc_pkg::SAMPLE_W-1:0] sample
    );
        logic [lfmc_pkg::BAR_COUNT-1:0] t;
        for (int k = 0; k < lfmc_pkg::BAR_COUNT; k++)
        begin
            t[k] = 32'(sample) >= 32'(lfmc_pkg::BAR_STEP * (k + 1));
        end
        return t;
    endfunction

    // A reading below the threshold means the sensor sees the line.
    assign line.left   = left_sample   < line_threshold;
    assign line.middle = middle_sample < line_threshold;
    assign line.right  = right_sample  < line_threshold;

    // Assemble the shift register word.
    always_comb
    begin
        bar_word = '0;
        bar_word[lfmc_pkg::MARK_BIT] = 1'b1;
        bar_word[0 +: lfmc_pkg::BAR_COUNT]                     = thermo(left_sample);
        bar_word[lfmc_pkg::MIDDLE_BASE +: lfmc_pkg::BAR_COUNT] = thermo(middle_sample);
        bar_word[lfmc_pkg::RIGHT_BASE +: lfmc_pkg::BAR_COUNT]  = thermo(right_sample);
        bar_word[lfmc_pkg::LEFT_LINE_BIT]   = line.left;
        bar_word[lfmc_pkg::MIDDLE_LINE_BIT] = line.middle;
        bar_word[lfmc_pkg::RIGHT_LINE_BIT]  = line.right;
    end

endmodule

[rtl/lfmc_core.sv]
// Mode state machine, blink timers, line follower decision and result builder.
// Depends on lfmc_pkg and lfmc_bar_encode.

module lfmc_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  lfmc_pkg::item_t                item,
    input  logic [lfmc_pkg::THR_W-1:0]     line_threshold,
    input  lfmc_pkg::blink_tgt_t           tgt,
    output lfmc_pkg::res_t                 res
);

    lfmc_pkg::mode_t                mode_reg, mode_next;
    logic                           driving_reg, driving_next;
    logic                           test_reg, test_next;
    logic                           last_left_reg, last_left_next;
    logic                           last_right_reg, last_right_next;
    logic [lfmc_pkg::IV_W-1:0]      idle_timer_reg, idle_timer_next;
    logic [lfmc_pkg::IV_W-1:0]      remote_timer_reg, remote_timer_next;
    logic [lfmc_pkg::CNT_W-1:0]     trouble_cnt_reg, trouble_cnt_next;

    logic [lfmc_pkg::WORD_W-1:0]    sense_word;
    lfmc_pkg::line_t                line;
    logic [3:0]                     idle_hit;
    logic [3:0]                     remote_hit;
    logic [lfmc_pkg::IV_W-1:0]      idle_timer_inc;
    logic [lfmc_pkg::IV_W-1:0]      remote_timer_inc;
    lfmc_pkg::motor_t               drive_motor;
    lfmc_pkg::msg_t                 drive_msg;
    logic                           drive_left;
    logic                           drive_right;
    logic                           sensing;

    // Blink pattern for the first matching target.
    function automatic logic [lfmc_pkg::WORD_W-1:0] blink_pattern(input logic [3:0] hit);
        logic [lfmc_pkg::WORD_W-1:0] w;
        w = '0;
        if (hit[0])
        begin
            w[lfmc_pkg::LEFT_LINE_BIT] = 1'b1;
        end
        else if (hit[1])
        begin
            w[lfmc_pkg::MIDDLE_LINE_BIT] = 1'b1;
        end
        else if (hit[2])
        begin
            w[lfmc_pkg::RIGHT_LINE_BIT] = 1'b1;
        end
        else if (hit[3])
        begin
            w[lfmc_pkg::MIDDLE_LINE_BIT] = 1'b1;
        end
        return w;
    endfunction

    // Timer advance: the last target restarts the count from zero.
    function automatic logic [lfmc_pkg::IV_W-1:0] blink_advance(
        input logic [lfmc_pkg::IV_W-1:0] timer,
        input logic [3:0]                hit
    );
        logic [lfmc_pkg::IV_W-1:0] r;
        if (hit[3] && !(|hit[2:0]))
        begin
            r = lfmc_pkg::IV_W'(1);
        end
        else
        begin
            r = timer + lfmc_pkg::IV_W'(1);
        end
        return r;
    endfunction

    lfmc_bar_encode u_bar_encode (
        .left_sample    (item.left_sample),
        .middle_sample  (item.middle_sample),
        .right_sample   (item.right_sample),
        .line_threshold (line_threshold),
        .bar_word       (sense_word),
        .line           (line)
    );

    assign sensing = test_reg | driving_reg;

    // Blink target matches, compared at full width.
    assign idle_hit[0]   = 34'(idle_timer_reg) == 34'(tgt.i1);
    assign idle_hit[1]   = 34'(idle_timer_reg) == 34'(tgt.i2);
    assign idle_hit[2]   = 34'(idle_timer_reg) == tgt.i3;
    assign idle_hit[3]   = 34'(idle_timer_reg) == tgt.i4;
    assign remote_hit[0] = 34'(remote_timer_reg) == 34'(tgt.half);
    assign remote_hit[1] = 34'(remote_timer_reg) == 34'(tgt.i1);
    assign remote_hit[2] = 34'(remote_timer_reg) == 34'(tgt.three_half);
    assign remote_hit[3] = 34'(remote_timer_reg) == 34'(tgt.i2);

    assign idle_timer_inc   = blink_advance(idle_timer_reg, idle_hit);
    assign remote_timer_inc = blink_advance(remote_timer_reg, remote_hit);

    // Line follower decision; with no line in view the last seen side wins.
    always_comb
    begin
        drive_left  = last_left_reg;
        drive_right = last_right_reg;
        if (line.middle)
        begin
            drive_motor = lfmc_pkg::MOTOR_FWD;
            drive_msg   = lfmc_pkg::MSG_BAR;
            drive_left  = 1'b0;
            drive_right = 1'b0;
        end
        else if (line.right)
        begin
            drive_motor = lfmc_pkg::MOTOR_TURN_R;
            drive_msg   = lfmc_pkg::MSG_SLASH;
            drive_left  = 1'b0;
            drive_right = 1'b1;
        end
        else if (line.left)
        begin
            drive_motor = lfmc_pkg::MOTOR_TURN_L;
            drive_msg   = lfmc_pkg::MSG_BACKSLASH;
            drive_left  = 1'b1;
            drive_right = 1'b0;
        end
        else if (last_left_reg)
        begin
            drive_motor = lfmc_pkg::MOTOR_ROT_L;
            drive_msg   = lfmc_pkg::MSG_LT;
        end
        else if (last_right_reg)
        begin
            drive_motor = lfmc_pkg::MOTOR_ROT_R;
            drive_msg   = lfmc_pkg::MSG_GT;
        end
        else
        begin
            drive_motor = lfmc_pkg::MOTOR_FWD;
            drive_msg   = lfmc_pkg::MSG_BAR;
        end
    end

    // Next state.
    always_comb
    begin
        mode_next         = mode_reg;
        driving_next      = driving_reg;
        test_next         = test_reg;
        last_left_next    = last_left_reg;
        last_right_next   = last_right_reg;
        idle_timer_next   = idle_timer_reg;
        remote_timer_next = remote_timer_reg;
        trouble_cnt_next  = trouble_cnt_reg;
        if (!item.action)
        begin
            if (mode_reg == lfmc_pkg::MODE_REMOTE)
            begin
                if (item.command_char == lfmc_pkg::CH_EXIT)
                begin
                    mode_next = lfmc_pkg::MODE_NORMAL;
                end
            end
            else
            begin
                // Pause and trouble fall back to normal before the command is taken.
                mode_next = lfmc_pkg::MODE_NORMAL;
                case (item.command_char)
                    lfmc_pkg::CH_START:
                    begin
                        driving_next = 1'b1;
                    end
                    lfmc_pkg::CH_REMOTE:
                    begin
                        mode_next         = lfmc_pkg::MODE_REMOTE;
                        remote_timer_next = tgt.i1;
                    end
                    lfmc_pkg::CH_PAUSE:
                    begin
                        mode_next = lfmc_pkg::MODE_PAUSE;
                    end
                    lfmc_pkg::CH_TROUBLE:
                    begin
                        mode_next        = lfmc_pkg::MODE_TROUBLE;
                        trouble_cnt_next = '0;
                    end
                    lfmc_pkg::CH_TEST:
                    begin
                        test_next    = ~test_reg;
                        driving_next = ~test_reg;
                    end
                    default:
                    begin
                        test_next    = 1'b0;
                        driving_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            case (mode_reg)
                lfmc_pkg::MODE_NORMAL:
                begin
                    if (!sensing)
                    begin
                        idle_timer_next = idle_timer_inc;
                    end
                    if (driving_reg)
                    begin
                        last_left_next  = drive_left;
                        last_right_next = drive_right;
                    end
                end
                lfmc_pkg::MODE_REMOTE:
                begin
                    remote_timer_next = remote_timer_inc;
                end
                lfmc_pkg::MODE_TROUBLE:
                begin
                    trouble_cnt_next = trouble_cnt_reg + lfmc_pkg::CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result word.
    always_comb
    begin
        res = '0;
        if (!item.action)
        begin
            if (mode_reg == lfmc_pkg::MODE_REMOTE)
            begin
                case (item.command_char)
                    lfmc_pkg::CH_FWD:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_FWD;
                        res.message   = lfmc_pkg::MSG_W;
                    end
                    lfmc_pkg::CH_LEFT:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_TURN_L;
                        res.message   = lfmc_pkg::MSG_A;
                    end
                    lfmc_pkg::CH_BACK:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_BACK;
                        res.message   = lfmc_pkg::MSG_S;
                    end
                    lfmc_pkg::CH_RIGHT:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_TURN_R;
                        res.message   = lfmc_pkg::MSG_D;
                    end
                    lfmc_pkg::CH_ROT_L:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_ROT_L;
                        res.message   = lfmc_pkg::MSG_Q;
                    end
                    lfmc_pkg::CH_ROT_R:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_ROT_R;
                        res.message   = lfmc_pkg::MSG_E;
                    end
                    lfmc_pkg::CH_EXIT:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        res.message   = lfmc_pkg::MSG_EXIT;
                    end
                    lfmc_pkg::CH_REPORT:
                    begin
                        res.telemetry_valid = 1'b1;
                        res.report_left     = item.left_sample;
                        res.report_middle   = item.middle_sample;
                        res.report_right    = item.right_sample;
                    end
                    default:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        res.message   = lfmc_pkg::MSG_X;
                    end
                endcase
            end
            else
            begin
                case (item.command_char)
                    lfmc_pkg::CH_START:
                    begin
                        res.message = lfmc_pkg::MSG_START;
                    end
                    lfmc_pkg::CH_REMOTE:
                    begin
                        res.message = lfmc_pkg::MSG_REMOTE;
                    end
                    lfmc_pkg::CH_PAUSE:
                    begin
                        res.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        res.message   = lfmc_pkg::MSG_PAUSE;
                    end
                    lfmc_pkg::CH_TROUBLE:
                    begin
                        res.message = lfmc_pkg::MSG_TROUBLE;
                    end
                    lfmc_pkg::CH_TEST:
                    begin
                    end
                    default:
                    begin
                        // Unknown command: stop and clear the bar graph.
                        res.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        res.bar_valid = 1'b1;
                        res.message   = lfmc_pkg::MSG_SAD;
                    end
                endcase
            end
        end
        else
        begin
            case (mode_reg)
                lfmc_pkg::MODE_NORMAL:
                begin
                    if (sensing)
                    begin
                        res.bar_valid = 1'b1;
                        res.bar_word  = sense_word;
                    end
                    else
                    begin
                        res.bar_valid = |idle_hit;
                        res.bar_word  = blink_pattern(idle_hit);
                    end
                    if (test_reg)
                    begin
                        res.telemetry_valid = 1'b1;
                        res.report_left     = item.left_sample;
                        res.report_middle   = item.middle_sample;
                        res.report_right    = item.right_sample;
                    end
                    if (driving_reg)
                    begin
                        res.motor_cmd = drive_motor;
                        res.message   = drive_msg;
                    end
                end
                lfmc_pkg::MODE_REMOTE:
                begin
                    res.bar_valid = |remote_hit;
                    res.bar_word  = blink_pattern(remote_hit);
                end
                lfmc_pkg::MODE_TROUBLE:
                begin
                    res.bar_valid = 1'b1;
                    res.bar_word  = lfmc_pkg::WORD_W'(trouble_cnt_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers advance once per word taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= lfmc_pkg::MODE_NORMAL;
            driving_reg      <= 1'b0;
            test_reg         <= 1'b0;
            last_left_reg    <= 1'b0;
            last_right_reg   <= 1'b0;
            idle_timer_reg   <= lfmc_pkg::INTERVAL_RESET;
            remote_timer_reg <= lfmc_pkg::INTERVAL_RESET;
            trouble_cnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            driving_reg      <= driving_next;
            test_reg         <= test_next;
            last_left_reg    <= last_left_next;
            last_right_reg   <= last_right_next;
            idle_timer_reg   <= idle_timer_next;
            remote_timer_reg <= remote_timer_next;
            trouble_cnt_reg  <= trouble_cnt_next;
        end
    end

endmodule

[rtl/line_follower_mode_controller.sv]
// Top level of the line follower mode controller: ports, configuration
// registers, input register and result register. Depends on lfmc_pkg and lfmc_core.
//
//   Channel   Handshake               Word
//   input     in_valid / in_stall     action, command_char, three samples
//   output    out_valid / out_stall   motor, bar graph, message, telemetry
//   config    cfg_write_en            cfg_index, cfg_data (no read-back)
//
// A word is registered on acceptance and its result is then registered in the
// result register; one word is taken every cycle while out_stall is low.
// The mode logic sits between the two registers.
// Reset returns to normal mode with all flags clear and both timers at 1000.
// A stalled result holds the result register; the input register then holds
// its word and in_stall is raised until the result is taken.

module line_follower_mode_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [7:0]                         command_char,
    input  logic [lfmc_pkg::SAMPLE_W-1:0]      left_sample,
    input  logic [lfmc_pkg::SAMPLE_W-1:0]      middle_sample,
    input  logic [lfmc_pkg::SAMPLE_W-1:0]      right_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         motor_cmd,
    output logic                               bar_valid,
    output logic [lfmc_pkg::WORD_W-1:0]        bar_word,
    output logic [4:0]                         message,
    output logic                               telemetry_valid,
    output logic [lfmc_pkg::SAMPLE_W-1:0]      report_left,
    output logic [lfmc_pkg::SAMPLE_W-1:0]      report_middle,
    output logic [lfmc_pkg::SAMPLE_W-1:0]      report_right,
    input  logic                               cfg_write_en,
    input  logic [lfmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lfmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                              item_valid_reg, item_valid_next;
    lfmc_pkg::item_t                   item_reg;
    logic                              out_valid_reg, out_valid_next;
    lfmc_pkg::res_t                    res_reg;
    lfmc_pkg::res_t                    res_comb;
    logic [lfmc_pkg::THR_W-1:0]        threshold_reg;
    lfmc_pkg::blink_tgt_t              tgt_reg;
    logic                              step;
    logic                              in_take;

    // The input word moves on whenever the result register is free or being emptied.
    assign step            = item_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall        = item_valid_reg & ~step;
    assign in_take         = in_valid & ~in_stall;
    assign item_valid_next = in_stall | in_valid;
    assign out_valid_next  = step | (out_valid_reg & out_stall);

    // Configuration registers; the blink targets are derived at write time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= lfmc_pkg::THRESHOLD_RESET;
            tgt_reg       <= lfmc_pkg::blink_targets(lfmc_pkg::INTERVAL_RESET);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                lfmc_pkg::CFG_LINE_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[lfmc_pkg::THR_W-1:0];
                end
                lfmc_pkg::CFG_BLINK_INTERVAL:
                begin
                    tgt_reg <= lfmc_pkg::blink_targets(cfg_data[lfmc_pkg::IV_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Valid flags of the two register stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input word register, samples trimmed to the converter width.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.action        <= action;
            item_reg.command_char  <= command_char;
            item_reg.left_sample   <= left_sample & lfmc_pkg::SAMPLE_MASK;
            item_reg.middle_sample <= middle_sample & lfmc_pkg::SAMPLE_MASK;
            item_reg.right_sample  <= right_sample & lfmc_pkg::SAMPLE_MASK;
        end
    end

    lfmc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .item           (item_reg),
        .line_threshold (threshold_reg),
        .tgt            (tgt_reg),
        .res            (res_comb)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid       = out_valid_reg;
    assign motor_cmd       = res_reg.motor_cmd;
    assign bar_valid       = res_reg.bar_valid;
    assign bar_word        = res_reg.bar_word;
    assign message         = res_reg.message;
    assign telemetry_valid = res_reg.telemetry_valid;
    assign report_left     = res_reg.report_left;
    assign report_middle   = res_reg.report_middle;
    assign report_right    = res_reg.report_right;

endmodule

[rtl/lfmc_checker.sv]
// Port level checks for the line follower mode controller, bound to the top level.
// Depends only on the top level's ports.

module lfmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        bar_valid,
    input logic [31:0] bar_word,
    input logic [4:0]  message,
    input logic        telemetry_valid,
    input logic [11:0] report_left,
    input logic [11:0] report_middle,
    input logic [11:0] report_right
);

    // An empty result register never holds back the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register is empty");

    // A result that is not taken stays on the outputs.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(message) && $stable(bar_word))
        else $error("stalled result changed");

    // Without a bar graph word the word reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bar_valid |-> bar_word == 32'd0)
        else $error("bar word set without bar_valid");

    // Without telemetry the report fields read zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !telemetry_valid |->
            report_left == 12'd0 && report_middle == 12'd0 && report_right == 12'd0)
        else $error("report fields set without telemetry_valid");

endmodule

bind line_follower_mode_controller lfmc_checker u_lfmc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .bar_valid       (bar_valid),
    .bar_word        (bar_word),
    .message         (message),
    .telemetry_valid (telemetry_valid),
    .report_left     (report_left),
    .report_middle   (report_middle),
    .report_right    (report_right)
);

[verif/line_follower_mode_controller_tb.sv]
// Self-checking testbench for line_follower_mode_controller: a directed table, then random words
// in phases of threshold, blink interval and handshake pressure, checked against a predictor
// or hand-typed values. Depends on lfmc_pkg and the RTL of the block only.

module line_follower_mode_controller_tb;

    localparam int TIMEOUT_UNITS = 2_000_000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int REPORT_LIMIT  = 10;

    // A character that is a command in neither normal nor remote mode ('X').
    localparam logic [7:0] CH_STRAY = 8'h58;

    // One row of the directed table; has_value marks an expectation typed in by hand.
    typedef struct {
        logic has_value;
        lfmc_pkg::item_t word;
        lfmc_pkg::res_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [7:0] command_char = 8'h00;
    logic [lfmc_pkg::SAMPLE_W-1:0] left_sample = '0;
    logic [lfmc_pkg::SAMPLE_W-1:0] middle_sample = '0;
    logic [lfmc_pkg::SAMPLE_W-1:0] right_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] motor_cmd;
    logic bar_valid;
    logic [lfmc_pkg::WORD_W-1:0] bar_word;
    logic [4:0] message;
    logic telemetry_valid;
    logic [lfmc_pkg::SAMPLE_W-1:0] report_left;
    logic [lfmc_pkg::SAMPLE_W-1:0] report_middle;
    logic [lfmc_pkg::SAMPLE_W-1:0] report_right;
    logic cfg_write_en = 1'b0;
    logic [lfmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lfmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Handshake pressure of the current phase, in percent.
    int idle_pct = 0;
    int stall_pct = 0;

    int fault_count = 0;
    int results_seen = 0;
    lfmc_pkg::res_t awaited_results[$];
    dir_row_t directed_rows[$];

    // Predictor copy of the registers and of the controller state.
    logic [lfmc_pkg::THR_W-1:0] threshold = lfmc_pkg::THRESHOLD_RESET;
    logic [lfmc_pkg::IV_W-1:0] interval = lfmc_pkg::INTERVAL_RESET;
    lfmc_pkg::mode_t cur_mode = lfmc_pkg::MODE_NORMAL;
    logic driving = 1'b0;
    logic testing = 1'b0;
    logic saw_left = 1'b0;
    logic saw_right = 1'b0;
    logic [31:0] idle_timer = lfmc_pkg::INTERVAL_RESET;
    logic [31:0] remote_timer = lfmc_pkg::INTERVAL_RESET;
    logic [lfmc_pkg::CNT_W-1:0] trouble_cnt = '0;

    line_follower_mode_controller i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .command_char    (command_char),
        .left_sample     (left_sample),
        .middle_sample   (middle_sample),
        .right_sample    (right_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .motor_cmd       (motor_cmd),
        .bar_valid       (bar_valid),
        .bar_word        (bar_word),
        .message         (message),
        .telemetry_valid (telemetry_valid),
        .report_left     (report_left),
        .report_middle   (report_middle),
        .report_right    (report_right),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // Thermometer of sample/410, saturating at nine bars.
    function automatic logic [8:0] bar_fill(input logic [lfmc_pkg::SAMPLE_W-1:0] s);
        int n;
        n = s / lfmc_pkg::BAR_STEP;
        if (n > lfmc_pkg::BAR_COUNT)
            n = lfmc_pkg::BAR_COUNT;
        return 9'((1 << n) - 1);
    endfunction

    // One blink timer step: a hit on a target sends its bit, the last target restarts at 0.
    function automatic logic [31:0] blink_step(input logic [31:0] timer,
                                               input logic [63:0] t1, t2, t3, t4,
                                               inout lfmc_pkg::res_t r);
        logic [63:0] t;
        t = 64'(timer);
        if (t == t1)
        begin
            r.bar_valid = 1'b1;
            r.bar_word = 32'd1 << lfmc_pkg::LEFT_LINE_BIT;
        end
        else if (t == t2)
        begin
            r.bar_valid = 1'b1;
            r.bar_word = 32'd1 << lfmc_pkg::MIDDLE_LINE_BIT;
        end
        else if (t == t3)
        begin
            r.bar_valid = 1'b1;
            r.bar_word = 32'd1 << lfmc_pkg::RIGHT_LINE_BIT;
        end
        else if (t == t4)
        begin
            r.bar_valid = 1'b1;
            r.bar_word = 32'd1 << lfmc_pkg::MIDDLE_LINE_BIT;
            t = 64'd0;
        end
        return 32'(t + 64'd1);
    endfunction

    // Advance the predicted controller by one accepted word and return its result.
    function automatic lfmc_pkg::res_t controller_step(input lfmc_pkg::item_t w);
        lfmc_pkg::res_t r;
        logic seen_l;
        logic seen_m;
        logic seen_r;
        logic [63:0] iv;
        r = '0;
        iv = 64'(interval);
        seen_l = 1'b0;
        seen_m = 1'b0;
        seen_r = 1'b0;
        if (!w.action)
        begin
            if (cur_mode == lfmc_pkg::MODE_REMOTE)
            begin
                // Remote drive keys.
                case (w.command_char)
                    lfmc_pkg::CH_FWD:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_FWD;
                        r.message = lfmc_pkg::MSG_W;
                    end
                    lfmc_pkg::CH_LEFT:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_TURN_L;
                        r.message = lfmc_pkg::MSG_A;
                    end
                    lfmc_pkg::CH_BACK:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_BACK;
                        r.message = lfmc_pkg::MSG_S;
                    end
                    lfmc_pkg::CH_RIGHT:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_TURN_R;
                        r.message = lfmc_pkg::MSG_D;
                    end
                    lfmc_pkg::CH_ROT_L:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_ROT_L;
                        r.message = lfmc_pkg::MSG_Q;
                    end
                    lfmc_pkg::CH_ROT_R:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_ROT_R;
                        r.message = lfmc_pkg::MSG_E;
                    end
                    lfmc_pkg::CH_EXIT:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        r.message = lfmc_pkg::MSG_EXIT;
                        cur_mode = lfmc_pkg::MODE_NORMAL;
                    end
                    lfmc_pkg::CH_REPORT:
                    begin
                        r.telemetry_valid = 1'b1;
                        r.report_left = w.left_sample;
                        r.report_middle = w.middle_sample;
                        r.report_right = w.right_sample;
                    end
                    default:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        r.message = lfmc_pkg::MSG_X;
                    end
                endcase
            end
            else
            begin
                // Pause and trouble fall back to normal before the command is read.
                cur_mode = lfmc_pkg::MODE_NORMAL;
                case (w.command_char)
                    lfmc_pkg::CH_START:
                    begin
                        r.message = lfmc_pkg::MSG_START;
                        driving = 1'b1;
                    end
                    lfmc_pkg::CH_REMOTE:
                    begin
                        r.message = lfmc_pkg::MSG_REMOTE;
                        cur_mode = lfmc_pkg::MODE_REMOTE;
                        remote_timer = interval;
                    end
                    lfmc_pkg::CH_PAUSE:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        r.message = lfmc_pkg::MSG_PAUSE;
                        cur_mode = lfmc_pkg::MODE_PAUSE;
                    end
                    lfmc_pkg::CH_TROUBLE:
                    begin
                        r.message = lfmc_pkg::MSG_TROUBLE;
                        cur_mode = lfmc_pkg::MODE_TROUBLE;
                        trouble_cnt = '0;
                    end
                    lfmc_pkg::CH_TEST:
                    begin
                        testing = !testing;
                        driving = testing;
                    end
                    default:
                    begin
                        r.motor_cmd = lfmc_pkg::MOTOR_STOP;
                        r.bar_valid = 1'b1;
                        r.message = lfmc_pkg::MSG_SAD;
                        testing = 1'b0;
                        driving = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            case (cur_mode)
                lfmc_pkg::MODE_NORMAL:
                begin
                    // Bar graph while driving or testing, idle blink otherwise.
                    if (testing || driving)
                    begin
                        seen_l = w.left_sample < threshold;
                        seen_m = w.middle_sample < threshold;
                        seen_r = w.right_sample < threshold;
                        r.bar_valid = 1'b1;
                        r.bar_word = {1'b1, 1'b0, seen_r, bar_fill(w.right_sample),
                                      seen_m, bar_fill(w.middle_sample),
                                      seen_l, bar_fill(w.left_sample)};
                    end
                    else
                        idle_timer = blink_step(idle_timer, iv, 2 * iv, 3 * iv, 4 * iv, r);
                    if (testing)
                    begin
                        r.telemetry_valid = 1'b1;
                        r.report_left = w.left_sample;
                        r.report_middle = w.middle_sample;
                        r.report_right = w.right_sample;
                    end
                    // Line follower: middle wins, then right, then left, then the last side seen.
                    if (driving)
                    begin
                        if (seen_m)
                        begin
                            saw_left = 1'b0;
                            saw_right = 1'b0;
                            r.motor_cmd = lfmc_pkg::MOTOR_FWD;
                            r.message = lfmc_pkg::MSG_BAR;
                        end
                        else if (seen_r)
                        begin
                            saw_left = 1'b0;
                            saw_right = 1'b1;
                            r.motor_cmd = lfmc_pkg::MOTOR_TURN_R;
                            r.message = lfmc_pkg::MSG_SLASH;
                        end
                        else if (seen_l)
                        begin
                            saw_left = 1'b1;
                            saw_right = 1'b0;
                            r.motor_cmd = lfmc_pkg::MOTOR_TURN_L;
                            r.message = lfmc_pkg::MSG_BACKSLASH;
                        end
                        else if (saw_left)
                        begin
                            r.motor_cmd = lfmc_pkg::MOTOR_ROT_L;
                            r.message = lfmc_pkg::MSG_LT;
                        end
                        else if (saw_right)
                        begin
                            r.motor_cmd = lfmc_pkg::MOTOR_ROT_R;
                            r.message = lfmc_pkg::MSG_GT;
                        end
                        else
                        begin
                            r.motor_cmd = lfmc_pkg::MOTOR_FWD;
                            r.message = lfmc_pkg::MSG_BAR;
                        end
                    end
                end
                lfmc_pkg::MODE_REMOTE:
                    remote_timer = blink_step(remote_timer, iv / 2, iv, (3 * iv) / 2, 2 * iv, r);
                lfmc_pkg::MODE_TROUBLE:
                begin
                    r.bar_valid = 1'b1;
                    r.bar_word = 32'(trouble_cnt);
                    trouble_cnt = trouble_cnt + 1'b1;
                end
                default:
                    r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic lfmc_pkg::item_t tick_word(input logic [lfmc_pkg::SAMPLE_W-1:0] l, m, r);
        return '{1'b1, 8'h00, l, m, r};
    endfunction

    function automatic lfmc_pkg::item_t char_word(input logic [7:0] c);
        return '{1'b0, c, '0, '0, '0};
    endfunction

    function automatic lfmc_pkg::res_t plain_result(input lfmc_pkg::motor_t mc, input logic bv,
                                                    input logic [lfmc_pkg::WORD_W-1:0] bw,
                                                    input lfmc_pkg::msg_t mg);
        return '{mc, bv, bw, mg, 1'b0, '0, '0, '0};
    endfunction

    function automatic string show(input lfmc_pkg::res_t r);
        return $sformatf("motor=%0d bar=%0b/%08h msg=%0d tele=%0b/%03h/%03h/%03h",
                         r.motor_cmd, r.bar_valid, r.bar_word, r.message,
                         r.telemetry_valid, r.report_left, r.report_middle, r.report_right);
    endfunction

    // Samples lean toward the rails, the threshold edge and the bar boundaries.
    function automatic logic [lfmc_pkg::SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = 4095;
            2: v = int'(threshold) + int'($urandom_range(2)) - 1;
            3: v = lfmc_pkg::BAR_STEP * int'($urandom_range(1, 9)) - int'($urandom_range(1));
            default: v = int'($urandom_range(4095));
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[lfmc_pkg::SAMPLE_W-1:0];
    endfunction

    // Random word, mostly commands that make sense in the predicted mode.
    function automatic lfmc_pkg::item_t pick_word();
        lfmc_pkg::item_t w;
        int roll;
        w.action = ($urandom_range(99) < 55);
        w.command_char = 8'($urandom);
        w.left_sample = pick_sample();
        w.middle_sample = pick_sample();
        w.right_sample = pick_sample();
        roll = int'($urandom_range(99));
        if (!w.action)
        begin
            if (cur_mode == lfmc_pkg::MODE_REMOTE)
            begin
                if (roll < 70)
                begin
                    case ($urandom_range(6))
                        0: w.command_char = lfmc_pkg::CH_FWD;
                        1: w.command_char = lfmc_pkg::CH_LEFT;
                        2: w.command_char = lfmc_pkg::CH_BACK;
                        3: w.command_char = lfmc_pkg::CH_RIGHT;
                        4: w.command_char = lfmc_pkg::CH_ROT_L;
                        5: w.command_char = lfmc_pkg::CH_ROT_R;
                        default: w.command_char = lfmc_pkg::CH_REPORT;
                    endcase
                end
                else if (roll < 82)
                    w.command_char = lfmc_pkg::CH_EXIT;
            end
            else if (roll < 25)
                w.command_char = lfmc_pkg::CH_START;
            else if (roll < 40)
                w.command_char = lfmc_pkg::CH_TEST;
            else if (roll < 58)
                w.command_char = lfmc_pkg::CH_REMOTE;
            else if (roll < 68)
                w.command_char = lfmc_pkg::CH_PAUSE;
            else if (roll < 82)
                w.command_char = lfmc_pkg::CH_TROUBLE;
        end
        return w;
    endfunction

    // Offer one word, wait for its acceptance and queue what it should produce.
    task automatic send_word(input lfmc_pkg::item_t w, input logic has_value,
                             input lfmc_pkg::res_t fixed_res);
        lfmc_pkg::res_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= w.action;
        command_char <= w.command_char;
        left_sample <= w.left_sample;
        middle_sample <= w.middle_sample;
        right_sample <= w.right_sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = controller_step(w);
        awaited_results.push_back(has_value ? fixed_res : predicted);
    endtask

    // Wait until every queued result has been taken, then let the pipeline empty.
    task automatic settle();
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lfmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfmc_pkg::CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == lfmc_pkg::CFG_LINE_THRESHOLD)
            threshold = data[lfmc_pkg::THR_W-1:0];
        else
            interval = data;
        @(posedge clk);
    endtask

    // New register setting and handshake pressure, then a run of random words.
    task automatic run_phase(input logic [lfmc_pkg::THR_W-1:0] thr,
                             input logic [lfmc_pkg::IV_W-1:0] iv,
                             input int idle, input int stall, input int count);
        logic [63:0] rewind_iv;
        settle();
        idle_pct = 0;
        stall_pct = 0;
        write_reg(lfmc_pkg::CFG_LINE_THRESHOLD, lfmc_pkg::CFG_DATA_W'(thr));
        // The idle timer is not reloaded by a write, so a small interval would leave it
        // far past every target. Walk it through a restart with a wider interval first.
        if (64'(idle_timer) > 64'(iv) * 4)
        begin
            rewind_iv = (64'(idle_timer) + 64'd3) / 4;
            if (rewind_iv < 64'd2)
                rewind_iv = 64'd2;
            write_reg(lfmc_pkg::CFG_BLINK_INTERVAL, rewind_iv[31:0]);
            if (cur_mode == lfmc_pkg::MODE_REMOTE)
                send_word(char_word(lfmc_pkg::CH_EXIT), 1'b0, '0);
            send_word(char_word(CH_STRAY), 1'b0, '0);
            while (64'(idle_timer) >= rewind_iv)
                send_word(tick_word(pick_sample(), pick_sample(), pick_sample()), 1'b0, '0);
            in_valid <= 1'b0;
            settle();
        end
        write_reg(lfmc_pkg::CFG_BLINK_INTERVAL, iv);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) send_word(pick_word(), 1'b0, '0);
        in_valid <= 1'b0;
    endtask

    // Receiver stalls at random with the phase's pressure.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        lfmc_pkg::res_t got;
        lfmc_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{lfmc_pkg::motor_t'(motor_cmd), bar_valid, bar_word,
                    lfmc_pkg::msg_t'(message),
                    telemetry_valid, report_left, report_middle, report_right};
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing pending: %s",
                             results_seen, show(got));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("result %0d expected %s", results_seen, show(want));
                        $display("result %0d got      %s", results_seen, show(got));
                    end
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        // Directed table, run at the reset settings: threshold 2048, interval 1000.
        // Right after reset the idle timer sits on the first blink target.
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd100, 12'd100, 12'd100),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b1, 32'h0000_0200, lfmc_pkg::MSG_NONE)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd100, 12'd100, 12'd100),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_NONE)});
        // Pause, a silent pause tick, then trouble counting from zero.
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_PAUSE),
            plain_result(lfmc_pkg::MOTOR_STOP, 1'b0, 32'h0, lfmc_pkg::MSG_PAUSE)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd4095, 12'd0, 12'd4095),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_NONE)});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_TROUBLE),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_TROUBLE)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd0, 12'd0, 12'd0),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b1, 32'h0, lfmc_pkg::MSG_NONE)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd0, 12'd0, 12'd0),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b1, 32'h1, lfmc_pkg::MSG_NONE)});
        // Driving: all sensors on the line, then all off with full bars.
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_START),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_START)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd0, 12'd0, 12'd0),
            plain_result(lfmc_pkg::MOTOR_FWD, 1'b1, 32'hA008_0200, lfmc_pkg::MSG_BAR)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd4095, 12'd4095, 12'd4095),
            plain_result(lfmc_pkg::MOTOR_FWD, 1'b1, 32'h9FF7_FDFF, lfmc_pkg::MSG_BAR)});
        // Left seen, then lost: rotate left. Right seen, then lost: rotate right.
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd0, 12'd4095, 12'd4095), '0});
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd4095, 12'd4095, 12'd4095), '0});
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd4095, 12'd4095, 12'd0), '0});
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd4095, 12'd4095, 12'd4095), '0});
        // Threshold edge and bar boundaries.
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd2047, 12'd2048, 12'd3690), '0});
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd409, 12'd410, 12'd3689), '0});
        // Test mode on and off; it forces the driving flag to follow.
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_TEST),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_NONE)});
        directed_rows.push_back(dir_row_t'{1'b0, tick_word(12'd123, 12'd2500, 12'd4000), '0});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_TEST),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_NONE)});
        // Remote drive: entering reloads the timer, so the first tick hits the middle target.
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_REMOTE),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b0, 32'h0, lfmc_pkg::MSG_REMOTE)});
        directed_rows.push_back(dir_row_t'{1'b1, tick_word(12'd0, 12'd0, 12'd0),
            plain_result(lfmc_pkg::MOTOR_NONE, 1'b1, 32'h0008_0000, lfmc_pkg::MSG_NONE)});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_FWD),
            plain_result(lfmc_pkg::MOTOR_FWD, 1'b0, 32'h0, lfmc_pkg::MSG_W)});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_LEFT),
            plain_result(lfmc_pkg::MOTOR_TURN_L, 1'b0, 32'h0, lfmc_pkg::MSG_A)});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_ROT_R),
            plain_result(lfmc_pkg::MOTOR_ROT_R, 1'b0, 32'h0, lfmc_pkg::MSG_E)});
        directed_rows.push_back(dir_row_t'{1'b0,
            '{1'b0, lfmc_pkg::CH_REPORT, 12'hABC, 12'h123, 12'hFFF}, '0});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(CH_STRAY),
            plain_result(lfmc_pkg::MOTOR_STOP, 1'b0, 32'h0, lfmc_pkg::MSG_X)});
        directed_rows.push_back(dir_row_t'{1'b1, char_word(lfmc_pkg::CH_EXIT),
            plain_result(lfmc_pkg::MOTOR_STOP, 1'b0, 32'h0, lfmc_pkg::MSG_EXIT)});
        // Unknown character in normal mode: stop and an empty bar word.
        directed_rows.push_back(dir_row_t'{1'b1, char_word(8'hFF),
            plain_result(lfmc_pkg::MOTOR_STOP, 1'b1, 32'h0, lfmc_pkg::MSG_SAD)});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k].word, directed_rows[k].has_value, directed_rows[k].res);
        in_valid <= 1'b0;

        // Random phases across thresholds, intervals and handshake pressure.
        run_phase(12'd0, 32'd2, 0, 0, 175);
        run_phase(12'd4095, 32'd3, 55, 0, 175);
        run_phase(12'($urandom_range(1, 4094)), 32'hFFFF_FFFF, 0, 55, 175);
        run_phase(12'($urandom_range(1, 4094)), 32'd5, 29, 29, 175);
        run_phase(12'd2048, 32'($urandom_range(2, 64)), 0, 0, 175);

        // A long trouble run so the counter wraps past 255.
        settle();
        if (cur_mode == lfmc_pkg::MODE_REMOTE)
            send_word(char_word(lfmc_pkg::CH_EXIT), 1'b0, '0);
        send_word(char_word(lfmc_pkg::CH_TROUBLE), 1'b0, '0);
        repeat (260) send_word(tick_word(pick_sample(), pick_sample(), pick_sample()), 1'b0, '0);
        in_valid <= 1'b0;

        settle();
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
